FILE: sv/lprs_pkg.sv
// Shared types and constants for the lane point row search unit.
`timescale 1ns / 1ps

package lprs_pkg;

    // Width of lane x positions on the ports
    localparam int X_W = 11;

    // Configuration register indexes
    localparam logic [2:0] REG_ROW_WIDTH   = 3'd0;
    localparam logic [2:0] REG_CONT_WINDOW = 3'd1;
    localparam logic [2:0] REG_TRACK_THR   = 3'd2;
    localparam logic [2:0] REG_CENTER_OFS  = 3'd3;
    localparam logic [2:0] REG_SCAN_INWARD = 3'd4;

    // Request kinds carried on the input tuser
    localparam logic CMD_START = 1'b0;
    localparam logic CMD_PIXEL = 1'b1;

    // Reset values of the configuration registers
    localparam logic [11:0] ROW_WIDTH_RST   = 12'd640;
    localparam logic [5:0]  CONT_WINDOW_RST = 6'd5;
    localparam logic [10:0] TRACK_THR_RST   = 11'd30;

    // Extra columns added to half the window to form the edge margin
    localparam int MARGIN_EXTRA = 2;

    // Outcome of one side at the end of a row
    typedef struct packed {
        logic [X_W-1:0] x;
        logic           found;
        logic           near;
    } side_result_t;

endpackage

FILE: sv/lprs_side.sv
// Per-side candidate tracker: continuity window, free and gated best white column.
`timescale 1ns / 1ps

module lprs_side #(
    parameter int SW = 14,
    parameter int XB = 11
) (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      start,
    input  logic                      pixel,
    input  logic signed [SW-1:0]      col,
    input  logic signed [SW-1:0]      lo,
    input  logic signed [SW-1:0]      hi,
    input  logic                      take_largest,
    input  logic [5:0]                win,
    input  logic [10:0]               threshold,
    input  logic [lprs_pkg::X_W-1:0]  prev_in,
    input  logic                      initial_in,
    output lprs_pkg::side_result_t    result
);

    logic [lprs_pkg::X_W-1:0] prev_reg, prev_next;
    logic                     init_reg, init_next;
    logic [XB-1:0]            free_x_reg, free_x_next;
    logic                     free_valid_reg, free_valid_next;
    logic [XB-1:0]            gated_x_reg, gated_x_next;
    logic                     gated_valid_reg, gated_valid_next;
    logic                     near_reg, near_next;

    logic signed [SW-1:0] prev_s;
    logic signed [SW-1:0] win_lo;
    logic signed [SW-1:0] win_hi;
    logic signed [SW-1:0] col_delta;
    logic signed [SW-1:0] delta_abs;
    logic                 near_hit;
    logic                 in_range;
    logic                 gate_ok;
    logic                 use_free;

    // Window and distance checks for the current column
    always_comb
    begin
        prev_s    = $signed({{(SW-lprs_pkg::X_W){1'b0}}, prev_reg});
        win_lo    = prev_s - $signed({{(SW-5){1'b0}}, win[5:1]});
        win_hi    = win_lo + $signed({{(SW-6){1'b0}}, win}) - $signed(SW'(1));
        near_hit  = pixel && (col >= win_lo) && (col <= win_hi);
        in_range  = pixel && (col >= lo) && (col <= hi);
        col_delta = col - prev_s;
        delta_abs = (col_delta < 0) ? -col_delta : col_delta;
        gate_ok   = delta_abs <= $signed({{(SW-11){1'b0}}, threshold});
    end

    // Clear on start, otherwise fold in the white column
    always_comb
    begin
        prev_next        = prev_reg;
        init_next        = init_reg;
        free_x_next      = free_x_reg;
        free_valid_next  = free_valid_reg;
        gated_x_next     = gated_x_reg;
        gated_valid_next = gated_valid_reg;
        near_next        = near_reg;
        if (start)
        begin
            prev_next        = prev_in;
            init_next        = initial_in;
            free_x_next      = '0;
            free_valid_next  = 1'b0;
            gated_x_next     = '0;
            gated_valid_next = 1'b0;
            near_next        = 1'b0;
        end
        else
        begin
            if (near_hit)
            begin
                near_next = 1'b1;
            end
            if (in_range && (take_largest || !free_valid_reg))
            begin
                free_x_next     = col[XB-1:0];
                free_valid_next = 1'b1;
            end
            if (in_range && gate_ok && (take_largest || !gated_valid_reg))
            begin
                gated_x_next     = col[XB-1:0];
                gated_valid_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prev_reg        <= '0;
            init_reg        <= 1'b0;
            free_x_reg      <= '0;
            free_valid_reg  <= 1'b0;
            gated_x_reg     <= '0;
            gated_valid_reg <= 1'b0;
            near_reg        <= 1'b0;
        end
        else
        begin
            prev_reg        <= prev_next;
            init_reg        <= init_next;
            free_x_reg      <= free_x_next;
            free_valid_reg  <= free_valid_next;
            gated_x_reg     <= gated_x_next;
            gated_valid_reg <= gated_valid_next;
            near_reg        <= near_next;
        end
    end

    // Pick the free candidate in initial mode or when the window was empty
    always_comb
    begin
        use_free = init_next || !near_next;
        if (use_free)
        begin
            result.found = free_valid_next;
            result.x     = free_valid_next ? lprs_pkg::X_W'(free_x_next) : prev_next;
        end
        else
        begin
            result.found = gated_valid_next;
            result.x     = gated_valid_next ? lprs_pkg::X_W'(gated_x_next) : prev_next;
        end
        result.near = near_next;
    end

endmodule

FILE: sv/lane_point_row_search_unit.sv
// Top level of the lane point row search unit: handshake, configuration, column count.
`timescale 1ns / 1ps

// Searches one binary image row for the left and right lane points. A start request
// (tuser low) latches the previous x and the initial-search flag of each side; then one
// pixel request per column follows (tuser high), the row's last one marked by tlast.
// The unit takes one request every clock cycle, except while a finished row waits on a busy
// output; each request is held in the input register while the column logic folds it into
// the side trackers, and the last pixel's result is loaded from there into the output register.
// A last pixel is held in the input register only while an earlier result still waits
// on the output. The rate is set by the per-column compare logic of the two side trackers.
// Configuration is written through cfg_we/cfg_index/cfg_data; the user must do so only
// while the unit is idle, as the unit itself does not enforce it.
module lane_point_row_search_unit #(
    parameter int MAX_WIDTH = 2048
) (
    input  logic        clk,
    input  logic        rst_n,
    // Configuration writes
    input  logic        cfg_we,
    input  logic [2:0]  cfg_index,
    input  logic [11:0] cfg_data,
    // Input requests
    input  logic        s_tvalid,
    output logic        s_tready,
    // pixel_white[0], left_prev_x[11:1], right_prev_x[22:12], left_initial[23],
    // right_initial[24], zero[31:25]
    input  logic [31:0] s_tdata,
    // command[0]
    input  logic        s_tuser,
    // pixel_last
    input  logic        s_tlast,
    // Results
    output logic        m_tvalid,
    input  logic        m_tready,
    // left_x[10:0], right_x[21:11], left_found[22], right_found[23],
    // left_continuous[24], right_continuous[25], zero[31:26]
    output logic [31:0] m_tdata
);

    localparam int CW = $clog2(MAX_WIDTH + 1);
    localparam int XB = $clog2(MAX_WIDTH);
    localparam int SW = ((CW > 12) ? CW : 12) + 2;

    // Configuration registers
    logic [11:0] row_width_reg;
    logic [5:0]  cont_window_reg;
    logic [10:0] track_thr_reg;
    logic [10:0] center_ofs_reg;
    logic        scan_inward_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            row_width_reg   <= lprs_pkg::ROW_WIDTH_RST;
            cont_window_reg <= lprs_pkg::CONT_WINDOW_RST;
            track_thr_reg   <= lprs_pkg::TRACK_THR_RST;
            center_ofs_reg  <= '0;
            scan_inward_reg <= 1'b0;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                lprs_pkg::REG_ROW_WIDTH:   row_width_reg   <= cfg_data;
                lprs_pkg::REG_CONT_WINDOW: cont_window_reg <= cfg_data[5:0];
                lprs_pkg::REG_TRACK_THR:   track_thr_reg   <= cfg_data[10:0];
                lprs_pkg::REG_CENTER_OFS:  center_ofs_reg  <= cfg_data[10:0];
                lprs_pkg::REG_SCAN_INWARD: scan_inward_reg <= cfg_data[0];
                default:                   ;
            endcase
        end
    end

    // Input register
    logic        in_valid_reg;
    logic [31:0] in_data_reg;
    logic        in_user_reg;
    logic        in_last_reg;
    logic        out_valid_reg;
    logic [31:0] out_data_reg;
    logic        out_free;
    logic        emits;
    logic        advance;

    assign out_free = !out_valid_reg || m_tready;
    assign emits    = (in_user_reg == lprs_pkg::CMD_PIXEL) && in_last_reg;
    assign advance  = in_valid_reg && (!emits || out_free);
    assign s_tready = !in_valid_reg || advance;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (s_tready)
        begin
            in_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_tready && s_tvalid)
        begin
            in_data_reg <= s_tdata;
            in_user_reg <= s_tuser;
            in_last_reg <= s_tlast;
        end
    end

    // Unpack the held request
    logic                     pixel_white;
    logic [lprs_pkg::X_W-1:0] left_prev_x;
    logic [lprs_pkg::X_W-1:0] right_prev_x;
    logic                     left_initial;
    logic                     right_initial;

    assign pixel_white   = in_data_reg[0];
    assign left_prev_x   = in_data_reg[11:1];
    assign right_prev_x  = in_data_reg[22:12];
    assign left_initial  = in_data_reg[23];
    assign right_initial = in_data_reg[24];

    // Column counter, saturating at the widest row
    logic [CW-1:0] col_count_reg, col_count_next;
    logic          is_start;
    logic          is_pixel;

    assign is_start = advance && (in_user_reg == lprs_pkg::CMD_START);
    assign is_pixel = advance && (in_user_reg == lprs_pkg::CMD_PIXEL);

    always_comb
    begin
        col_count_next = col_count_reg;
        if (is_start)
        begin
            col_count_next = '0;
        end
        else if (is_pixel && (col_count_reg < CW'(MAX_WIDTH)))
        begin
            col_count_next = col_count_reg + CW'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_count_reg <= '0;
        end
        else
        begin
            col_count_reg <= col_count_next;
        end
    end

    // Row geometry and scan ranges
    logic signed [SW-1:0] width_raw;
    logic signed [SW-1:0] width_s;
    logic signed [SW-1:0] half_s;
    logic signed [SW-1:0] margin_s;
    logic signed [SW-1:0] ofs_s;
    logic signed [SW-1:0] col_s;
    logic signed [SW-1:0] left_lo, left_hi, right_lo, right_hi;
    logic                 left_largest, right_largest;
    logic                 white_in_row;

    always_comb
    begin
        width_raw = $signed({{(SW-12){1'b0}}, row_width_reg});
        width_s   = (width_raw > $signed(SW'(MAX_WIDTH))) ? $signed(SW'(MAX_WIDTH)) : width_raw;
        half_s    = width_s >>> 1;
        margin_s  = $signed({{(SW-5){1'b0}}, cont_window_reg[5:1]})
                  + $signed(SW'(lprs_pkg::MARGIN_EXTRA));
        ofs_s     = $signed({{(SW-11){center_ofs_reg[10]}}, center_ofs_reg});
        col_s     = $signed({{(SW-CW){1'b0}}, col_count_reg});
        white_in_row = is_pixel && pixel_white && (col_s < width_s);
        if (!scan_inward_reg)
        begin
            // Edges inward: left takes the first white, right the last
            left_lo       = margin_s;
            left_hi       = width_s - margin_s - $signed(SW'(1));
            left_largest  = 1'b0;
            right_lo      = margin_s + $signed(SW'(1));
            right_hi      = width_s - margin_s;
            right_largest = 1'b1;
        end
        else
        begin
            // Center outward: left takes the last white, right the first
            left_lo       = margin_s + $signed(SW'(1));
            left_hi       = half_s + ofs_s;
            left_largest  = 1'b1;
            right_lo      = half_s - ofs_s;
            right_hi      = width_s - margin_s - $signed(SW'(1));
            right_largest = 1'b0;
        end
    end

    // Side trackers
    lprs_pkg::side_result_t left_res;
    lprs_pkg::side_result_t right_res;

    lprs_side #(
        .SW (SW),
        .XB (XB)
    ) u_left (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (is_start),
        .pixel        (white_in_row),
        .col          (col_s),
        .lo           (left_lo),
        .hi           (left_hi),
        .take_largest (left_largest),
        .win          (cont_window_reg),
        .threshold    (track_thr_reg),
        .prev_in      (left_prev_x),
        .initial_in   (left_initial),
        .result       (left_res)
    );

    lprs_side #(
        .SW (SW),
        .XB (XB)
    ) u_right (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (is_start),
        .pixel        (white_in_row),
        .col          (col_s),
        .lo           (right_lo),
        .hi           (right_hi),
        .take_largest (right_largest),
        .win          (cont_window_reg),
        .threshold    (track_thr_reg),
        .prev_in      (right_prev_x),
        .initial_in   (right_initial),
        .result       (right_res)
    );

    // Output register: load on the last pixel, drop when taken
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (advance && emits)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (m_tready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance && emits)
        begin
            out_data_reg <= {6'b0, right_res.near, left_res.near,
                             right_res.found, left_res.found, right_res.x, left_res.x};
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;

endmodule

FILE: dv/tb_lane_point_row_search_unit.sv
// Self-checking testbench for the lane point row search unit.
`timescale 1ns / 1ps

module tb_lane_point_row_search_unit;

    localparam int MAX_W = 2048;
    localparam int SINK_HOLD_CYCLES = 300;
    localparam int RANDOM_ITEMS = 1300;
    localparam int RANDOM_ROWS = 48;

    // One request as seen on the input stream
    typedef struct packed {
        logic        cmd;
        logic        white;
        logic        last;
        logic [10:0] lprev;
        logic [10:0] rprev;
        logic        linit;
        logic        rinit;
    } lane_step_t;

    // Result word, laid out as m_tdata
    typedef struct packed {
        logic [5:0]  pad;
        logic        right_cont;
        logic        left_cont;
        logic        right_found;
        logic        left_found;
        logic [10:0] right_x;
        logic [10:0] left_x;
    } row_result_t;

    // Directed row: request plus an optional hand-typed result
    typedef struct packed {
        logic        cmd;
        logic        white;
        logic        last;
        logic [10:0] lprev;
        logic [10:0] rprev;
        logic        linit;
        logic        rinit;
        logic        typed;
        logic [10:0] lx;
        logic [10:0] rx;
        logic        lf;
        logic        rf;
        logic        lc;
        logic        rc;
    } dir_row_t;

    // Register set of one phase
    typedef struct packed {
        logic [11:0]        row_width;
        logic [5:0]         window;
        logic [10:0]        thr;
        logic signed [10:0] offset;
        logic               inward;
    } search_cfg_t;

    // Best candidates of one side within the current row
    typedef struct packed {
        int free_x;
        bit free_ok;
        int gated_x;
        bit gated_ok;
        bit near;
    } side_track_t;

    logic        clk;
    logic        rst_n;
    logic        cfg_we;
    logic [2:0]  cfg_index;
    logic [11:0] cfg_data;
    logic        s_tvalid;
    logic        s_tready;
    logic [31:0] s_tdata;
    logic        s_tuser;
    logic        s_tlast;
    logic        m_tvalid;
    logic        m_tready;
    logic [31:0] m_tdata;

    // Predictor copy of the registers
    int cfg_row_width = int'(lprs_pkg::ROW_WIDTH_RST);
    int cfg_window    = int'(lprs_pkg::CONT_WINDOW_RST);
    int cfg_thr       = int'(lprs_pkg::TRACK_THR_RST);
    int cfg_offset    = 0;
    bit cfg_inward    = 1'b0;

    // Predictor copy of the row state
    int          req_lx = 0;
    int          req_rx = 0;
    bit          init_l = 1'b0;
    bit          init_r = 1'b0;
    int          col_count = 0;
    side_track_t trk_l = '0;
    side_track_t trk_r = '0;

    row_result_t expected_rows[$];
    int          err_count = 0;
    int          items_sent = 0;
    int          rows_due = 0;
    bit          calm = 1'b0;
    bit          sink_hold_req = 1'b0;

    // Directed requests at the reset register values
    //   cmd                  wht lst lprev rprev li ri chk  lx    rx    lf rf lc rc
    dir_row_t dir_table [26] = '{
        // pixels before any start, then more pixels after the last one
        '{lprs_pkg::CMD_PIXEL, 0, 1, 0,    0,    0, 0, 1, 0,    0,    0, 0, 0, 0},
        '{lprs_pkg::CMD_PIXEL, 1, 1, 0,    0,    0, 0, 1, 0,    0,    0, 0, 1, 1},
        // left in initial search, right tracking
        '{lprs_pkg::CMD_START, 0, 0, 5,    6,    1, 0, 0, 0,    0,    0, 0, 0, 0},
        '{lprs_pkg::CMD_PIXEL, 0, 0, 0,    0,    0, 0, 0, 0,    0,    0, 0, 0, 0},
        '{lprs_pkg::CMD_PIXEL, 0, 0, 0,    0,    0, 0, 0, 0,    0,    0, 0, 0, 0},
        '{lprs_pkg::CMD_PIXEL, 0, 0, 0,    0,    0, 0, 0, 0,    0,    0, 0, 0, 0},
        '{lprs_pkg::CMD_PIXEL, 0, 0, 0,    0,    0, 0, 0, 0,    0,    0, 0, 0, 0},
        '{lprs_pkg::CMD_PIXEL, 1, 0, 0,    0,    0, 0, 0, 0,    0,    0, 0, 0, 0},
        '{lprs_pkg::CMD_PIXEL, 0, 0, 0,    0,    0, 0, 0, 0,    0,    0, 0, 0, 0},
        '{lprs_pkg::CMD_PIXEL, 1, 0, 0,    0,    0, 0, 0, 0,    0,    0, 0, 0, 0},
        '{lprs_pkg::CMD_PIXEL, 0, 1, 0,    0,    0, 0, 1, 4,    6,    1, 1, 1, 1},
        // largest previous x, nothing found: keep previous
        '{lprs_pkg::CMD_START, 0, 0, 2047, 2047, 0, 0, 0, 0,    0,    0, 0, 0, 0},
        '{lprs_pkg::CMD_PIXEL, 1, 1, 0,    0,    0, 0, 1, 2047, 2047, 0, 0, 0, 0},
        // both sides initial on an all-white row
        '{lprs_pkg::CMD_START, 0, 0, 0,    0,    1, 1, 0, 0,    0,    0, 0, 0, 0},
        '{lprs_pkg::CMD_PIXEL, 1, 0, 0,    0,    0, 0, 0, 0,    0,    0, 0, 0, 0},
        '{lprs_pkg::CMD_PIXEL, 1, 0, 0,    0,    0, 0, 0, 0,    0,    0, 0, 0, 0},
        '{lprs_pkg::CMD_PIXEL, 1, 0, 0,    0,    0, 0, 0, 0,    0,    0, 0, 0, 0},
        '{lprs_pkg::CMD_PIXEL, 1, 0, 0,    0,    0, 0, 0, 0,    0,    0, 0, 0, 0},
        '{lprs_pkg::CMD_PIXEL, 1, 0, 0,    0,    0, 0, 0, 0,    0,    0, 0, 0, 0},
        '{lprs_pkg::CMD_PIXEL, 1, 1, 0,    0,    0, 0, 1, 4,    5,    1, 1, 1, 1},
        // start with junk in the pixel fields; right tracking rejects out of range
        '{lprs_pkg::CMD_START, 1, 1, 10,   4,    0, 0, 0, 0,    0,    0, 0, 0, 0},
        '{lprs_pkg::CMD_PIXEL, 0, 0, 0,    0,    0, 0, 0, 0,    0,    0, 0, 0, 0},
        '{lprs_pkg::CMD_PIXEL, 0, 0, 0,    0,    0, 0, 0, 0,    0,    0, 0, 0, 0},
        '{lprs_pkg::CMD_PIXEL, 0, 0, 0,    0,    0, 0, 0, 0,    0,    0, 0, 0, 0},
        '{lprs_pkg::CMD_PIXEL, 0, 0, 0,    0,    0, 0, 0, 0,    0,    0, 0, 0, 0},
        '{lprs_pkg::CMD_PIXEL, 1, 1, 0,    0,    0, 0, 0, 0,    0,    0, 0, 0, 0}
    };

    lane_point_row_search_unit #(
        .MAX_WIDTH(MAX_W)
    ) dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg_we   (cfg_we),
        .cfg_index(cfg_index),
        .cfg_data (cfg_data),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    initial clk = 1'b0;
    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    // Row width as the unit uses it
    function automatic int clamped_width();
        return (cfg_row_width > MAX_W) ? MAX_W : cfg_row_width;
    endfunction

    // Offer one white column to one side
    function automatic void offer_white(inout side_track_t s, input int col, input int lo,
                                        input int hi, input bit take_last, input int prev);
        int wlo;
        int whi;
        int gap;
        wlo = prev - cfg_window / 2;
        whi = wlo + cfg_window - 1;
        if (col >= wlo && col <= whi)
            s.near = 1'b1;
        if (col < lo || col > hi)
            return;
        if (take_last || !s.free_ok)
        begin
            s.free_x = col;
            s.free_ok = 1'b1;
        end
        gap = (col > prev) ? col - prev : prev - col;
        if (gap <= cfg_thr && (take_last || !s.gated_ok))
        begin
            s.gated_x = col;
            s.gated_ok = 1'b1;
        end
    endfunction

    // Choose the free or the gated candidate, else keep the previous x
    function automatic void side_pick(input side_track_t s, input bit init, input int prev,
                                      output logic [10:0] x, output logic found);
        bit use_free;
        use_free = init || !s.near;
        found = use_free ? s.free_ok : s.gated_ok;
        x = found ? (use_free ? s.free_x[10:0] : s.gated_x[10:0]) : prev[10:0];
    endfunction

    // Advance the row search by one request; return 1 when a result is due
    function automatic bit search_step(input lane_step_t st, output row_result_t res);
        int w;
        int m;
        int half;
        int col;
        res = '0;
        if (st.cmd == lprs_pkg::CMD_START)
        begin
            req_lx = int'(st.lprev);
            req_rx = int'(st.rprev);
            init_l = st.linit;
            init_r = st.rinit;
            col_count = 0;
            trk_l = '0;
            trk_r = '0;
            return 1'b0;
        end
        w = clamped_width();
        m = cfg_window / 2 + lprs_pkg::MARGIN_EXTRA;
        half = w / 2;
        col = col_count;
        if (st.white && col < w)
        begin
            if (!cfg_inward)
            begin
                offer_white(trk_l, col, m, w - m - 1, 1'b0, req_lx);
                offer_white(trk_r, col, m + 1, w - m, 1'b1, req_rx);
            end
            else
            begin
                offer_white(trk_l, col, m + 1, half + cfg_offset, 1'b1, req_lx);
                offer_white(trk_r, col, half - cfg_offset, w - m - 1, 1'b0, req_rx);
            end
        end
        if (col_count < MAX_W)
            col_count++;
        if (!st.last)
            return 1'b0;
        side_pick(trk_l, init_l, req_lx, res.left_x, res.left_found);
        side_pick(trk_r, init_r, req_rx, res.right_x, res.right_found);
        res.left_cont = trk_l.near;
        res.right_cont = trk_r.near;
        return 1'b1;
    endfunction

    task automatic report_mismatch(input string what, input int got, input int want);
        $display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $realtime);
        err_count++;
    endtask

    // Offer one request, wait for the handshake, then queue what it should produce
    task automatic send_item(input lane_step_t st, input bit typed, input row_result_t want);
        row_result_t res;
        if (!calm && $urandom_range(0, 9) == 0)
        begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 16)) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= st.cmd;
        s_tlast  <= st.last;
        s_tdata  <= {7'd0, st.rinit, st.linit, st.rprev, st.lprev, st.white};
        do
            @(posedge clk);
        while (!s_tready);
        items_sent++;
        if (search_step(st, res))
        begin
            expected_rows.push_back(typed ? want : res);
            rows_due++;
        end
    endtask

    // Drain all results and let the pipeline empty
    task automatic settle();
        s_tvalid <= 1'b0;
        while (expected_rows.size() != 0)
            @(posedge clk);
        repeat (8) @(posedge clk);
    endtask

    task automatic apply_setting(input search_cfg_t c);
        cfg_we    <= 1'b1;
        cfg_index <= lprs_pkg::REG_ROW_WIDTH;
        cfg_data  <= c.row_width;
        @(posedge clk);
        cfg_index <= lprs_pkg::REG_CONT_WINDOW;
        cfg_data  <= {6'd0, c.window};
        @(posedge clk);
        cfg_index <= lprs_pkg::REG_TRACK_THR;
        cfg_data  <= {1'b0, c.thr};
        @(posedge clk);
        cfg_index <= lprs_pkg::REG_CENTER_OFS;
        cfg_data  <= {1'b0, c.offset};
        @(posedge clk);
        cfg_index <= lprs_pkg::REG_SCAN_INWARD;
        cfg_data  <= {11'd0, c.inward};
        @(posedge clk);
        cfg_we <= 1'b0;
        cfg_row_width = int'(c.row_width);
        cfg_window = int'(c.window);
        cfg_thr = int'(c.thr);
        cfg_offset = int'(c.offset);
        cfg_inward = c.inward;
    endtask

    // Fixed settings first, most of them extreme, random ones after
    function automatic search_cfg_t choose_setting(input int phase);
        search_cfg_t c;
        int sel;
        c.row_width = 12'($urandom_range(16, 96));
        c.window = 6'(($urandom_range(0, 9) < 7) ? $urandom_range(1, 9) :
                                                   $urandom_range(0, 63));
        sel = $urandom_range(0, 9);
        c.thr = 11'((sel < 6) ? $urandom_range(0, 40) :
                    (sel < 9) ? $urandom_range(0, 2047) : ($urandom_range(0, 1) ? 2047 : 0));
        sel = $urandom_range(0, 9);
        c.offset = 11'((sel < 6) ? $urandom_range(0, 16) - 8 :
                       (sel < 9) ? $urandom_range(0, 2047) :
                                   ($urandom_range(0, 1) ? 32'h3FF : 32'h400));
        c.inward = 1'($urandom_range(0, 1));
        sel = $urandom_range(0, 19);
        if (sel == 14)
            c.row_width = 12'($urandom_range(0, 15));
        else if (sel < 17 && sel > 14)
            c.row_width = 12'($urandom_range(97, 400));
        else if (sel >= 17 && sel < 19)
            c.row_width = $urandom_range(0, 1) ? 12'd16 : 12'd2048;
        else if (sel == 19)
            c.row_width = 12'($urandom_range(2049, 4095));
        case (phase)
            // 16-column row, widest window: both scan ranges empty
            0:
            begin
                c.row_width = 12'd16; c.window = 6'd63; c.thr = 11'd0; c.offset = 11'h400;
                c.inward = 1'b0;
            end
            // widest row, one-column window, largest threshold
            1:
            begin
                c.row_width = 12'd2048; c.window = 6'd1; c.thr = 11'd2047; c.offset = 11'h3FF;
                c.inward = 1'b1;
            end
            // oversized row width, zero window
            2:
            begin
                c.row_width = 12'd4095; c.window = 6'd0; c.thr = 11'd30; c.offset = 11'd0;
                c.inward = 1'b0;
            end
            3:
            begin
                c.row_width = 12'd64; c.window = 6'd5; c.thr = 11'd10; c.offset = 11'd0;
                c.inward = 1'b1;
            end
            default:
            begin
            end
        endcase
        return c;
    endfunction

    function automatic logic [10:0] pick_prev(input int wc);
        case ($urandom_range(0, 9))
            0: return 11'd0;
            1: return 11'h7FF;
            2, 3: return 11'($urandom_range(0, 2047));
            default: return 11'((wc < 2) ? $urandom_range(0, 2047) : $urandom_range(0, wc - 1));
        endcase
    endfunction

    // Send one row: optional start, then pixels with whites clustered near the lanes
    task automatic send_row(input bit with_start, input int n_pix, input bit close);
        lane_step_t st;
        int i;
        int col;
        bit hot;
        if (with_start)
        begin
            st.cmd = lprs_pkg::CMD_START;
            st.white = 1'($urandom_range(0, 1));
            st.last = 1'($urandom_range(0, 1));
            st.lprev = pick_prev(clamped_width());
            st.rprev = pick_prev(clamped_width());
            st.linit = 1'($urandom_range(0, 1));
            st.rinit = 1'($urandom_range(0, 1));
            send_item(st, 1'b0, '0);
        end
        for (i = 0; i < n_pix; i++)
        begin
            col = col_count;
            hot = (col > req_lx - 7 && col < req_lx + 7) || (col > req_rx - 7 && col < req_rx + 7);
            st.cmd = lprs_pkg::CMD_PIXEL;
            st.white = hot ? 1'($urandom_range(0, 1)) : ($urandom_range(0, 11) == 0);
            st.last = close && (i == n_pix - 1);
            st.lprev = 11'($urandom_range(0, 2047));
            st.rprev = 11'($urandom_range(0, 2047));
            st.linit = 1'($urandom_range(0, 1));
            st.rinit = 1'($urandom_range(0, 1));
            send_item(st, 1'b0, '0);
        end
    endtask

    // Result side: random stall bursts, one long hold-off on request
    initial
    begin : sink_pacing
        m_tready <= 1'b0;
        wait (rst_n === 1'b1);
        forever
        begin
            @(posedge clk);
            if (sink_hold_req)
            begin
                m_tready <= 1'b0;
                repeat (SINK_HOLD_CYCLES) @(posedge clk);
                sink_hold_req = 1'b0;
                m_tready <= 1'b1;
            end
            else if (!calm && $urandom_range(0, 7) == 0)
            begin
                m_tready <= 1'b0;
                repeat ($urandom_range(1, 16)) @(posedge clk);
                m_tready <= 1'b1;
            end
            else
                m_tready <= 1'b1;
        end
    end

    // Compare each accepted result with the oldest expectation
    always @(posedge clk)
    begin : result_check
        row_result_t got;
        row_result_t want;
        if (rst_n && m_tvalid && m_tready)
        begin
            got = m_tdata;
            if (expected_rows.size() == 0)
                report_mismatch("result with none expected, word", int'(got), 0);
            else
            begin
                want = expected_rows.pop_front();
                if (got.left_x !== want.left_x)
                    report_mismatch("left_x", int'(got.left_x), int'(want.left_x));
                if (got.right_x !== want.right_x)
                    report_mismatch("right_x", int'(got.right_x), int'(want.right_x));
                if (got.left_found !== want.left_found)
                    report_mismatch("left_found", int'(got.left_found),
                                    int'(want.left_found));
                if (got.right_found !== want.right_found)
                    report_mismatch("right_found", int'(got.right_found),
                                    int'(want.right_found));
                if (got.left_cont !== want.left_cont)
                    report_mismatch("left_continuous", int'(got.left_cont),
                                    int'(want.left_cont));
                if (got.right_cont !== want.right_cont)
                    report_mismatch("right_continuous", int'(got.right_cont),
                                    int'(want.right_cont));
            end
        end
    end

    initial
    begin : stimulus
        search_cfg_t c;
        lane_step_t  st;
        row_result_t want;
        int          phase;
        int          r;
        int          n;
        int          wc;
        bit          full_row_done;
        rst_n     <= 1'b0;
        cfg_we    <= 1'b0;
        cfg_index <= lprs_pkg::REG_ROW_WIDTH;
        cfg_data  <= '0;
        s_tvalid  <= 1'b0;
        s_tdata   <= '0;
        s_tuser   <= lprs_pkg::CMD_START;
        s_tlast   <= 1'b0;
        full_row_done = 1'b0;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Walk the directed table
        foreach (dir_table[k])
        begin
            st = {dir_table[k].cmd, dir_table[k].white, dir_table[k].last, dir_table[k].lprev,
                  dir_table[k].rprev, dir_table[k].linit, dir_table[k].rinit};
            want = '0;
            want.left_x = dir_table[k].lx;
            want.right_x = dir_table[k].rx;
            want.left_found = dir_table[k].lf;
            want.right_found = dir_table[k].rf;
            want.left_cont = dir_table[k].lc;
            want.right_cont = dir_table[k].rc;
            send_item(st, dir_table[k].typed, want);
        end

        // Random phases, each with its own register setting
        items_sent = 0;
        rows_due = 0;
        phase = 0;
        while (items_sent < RANDOM_ITEMS || rows_due < RANDOM_ROWS)
        begin
            settle();
            c = choose_setting(phase);
            apply_setting(c);
            wc = clamped_width();
            // hold the result side off while short rows pile up
            if (phase == 3)
            begin
                sink_hold_req = 1'b1;
                repeat (30) send_row(1'b1, $urandom_range(1, 3), 1'b1);
            end
            for (r = 0; r < $urandom_range(3, 8) &&
                        (items_sent < RANDOM_ITEMS || rows_due < RANDOM_ROWS); r++)
            begin
                if (wc > 400)
                begin
                    // one long row on the first wide setting, short ones after
                    n = full_row_done ? $urandom_range(1, 120) : $urandom_range(400, 600);
                    full_row_done = 1'b1;
                end
                else
                begin
                    case ($urandom_range(0, 9))
                        0: n = $urandom_range(1, wc + 1);
                        1: n = wc + $urandom_range(1, 8);
                        default: n = wc;
                    endcase
                end
                if (n < 1)
                    n = 1;
                send_row($urandom_range(0, 9) != 0, n, $urandom_range(0, 19) != 0);
            end
            if (items_sent >= RANDOM_ITEMS - 300 && rows_due >= RANDOM_ROWS - 10)
                calm = 1'b1;
            phase++;
        end

        s_tvalid <= 1'b0;
        while (expected_rows.size() != 0)
            @(posedge clk);
        repeat (20) @(posedge clk);
        if (err_count == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

    // End a hung run
    initial
    begin : watchdog
        #4_000_000;
        $display("DONE: errors detected");
        $finish;
    end

endmodule

FILE: filelist.f
sv/lprs_pkg.sv
sv/lprs_side.sv
sv/lane_point_row_search_unit.sv
dv/tb_lane_point_row_search_unit.sv
